FILE: hw/rtl/aop_pkg.sv
// ============================================================================
// aop_pkg: shared constants for the box overlap penetration block
// Axis codes carried by each transaction, and the face index offset that
// marks a minus-side normal.
// ============================================================================
package aop_pkg;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // face index = axis, plus this offset when the minus side was kept
    localparam logic [2:0] FACE_MINUS_OFS = 3'd3;

endpackage

FILE: hw/rtl/aabb_overlap_penetration.sv
// ============================================================================
// aabb_overlap_penetration: box pair overlap and least-penetration axis
// Tests two axis-aligned boxes, one axis per transaction, and reports the
// face, depth and contact point of least penetration on the z transaction.
// ============================================================================
// Send three transactions per box pair, x then y then z (axis code 3 is
// dropped silently). Each transaction carries both boxes' local min, max and
// object position on that axis in signed fixed point (Q15.8 at 24 bits).
// The x and y transactions only update the stored per-axis depth, side and
// contact sum; the z transaction produces exactly one result transaction:
// hit is set when the least depth is positive, with face 0..5 (+x,+y,+z,
// -x,-y,-z), depth, and the contact point given as twice the midpoint of the
// overlap on each axis. Without a hit every other field is zero. Stored x
// and y values are zero after reset and are never cleared by a z, so a z
// without preceding x and y uses whatever was stored last. Throughput is one
// transaction per cycle except during the stall below; a z passes through one
// input register and one result register, with the depth adders and the
// three-way compare between them. The input side keeps accepting while a
// result waits on m_ready, stalling only when a z transaction sits in the
// input register behind an untaken result.
// ============================================================================
module aabb_overlap_penetration
    import aop_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_axis,
    input  logic signed [COORD_BITS-1:0] s_first_min,
    input  logic signed [COORD_BITS-1:0] s_first_max,
    input  logic signed [COORD_BITS-1:0] s_first_pos,
    input  logic signed [COORD_BITS-1:0] s_second_min,
    input  logic signed [COORD_BITS-1:0] s_second_max,
    input  logic signed [COORD_BITS-1:0] s_second_pos,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [2:0]                   m_face,
    output logic [COORD_BITS:0]          m_depth,
    output logic signed [COORD_BITS+1:0] m_contact_x,
    output logic signed [COORD_BITS+1:0] m_contact_y,
    output logic signed [COORD_BITS+1:0] m_contact_z
);

    // ---------------- input register ----------------
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [1:0]                   axis_reg;
    logic signed [COORD_BITS-1:0] first_min_reg;
    logic signed [COORD_BITS-1:0] first_max_reg;
    logic signed [COORD_BITS-1:0] first_pos_reg;
    logic signed [COORD_BITS-1:0] second_min_reg;
    logic signed [COORD_BITS-1:0] second_max_reg;
    logic signed [COORD_BITS-1:0] second_pos_reg;

    // ---------------- stored x and y results ----------------
    logic signed [COORD_BITS+1:0] axis_depth_reg   [2];
    logic                         axis_minus_reg   [2];
    logic signed [COORD_BITS+1:0] axis_contact_reg [2];

    // ---------------- result register ----------------
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         hit_reg;
    logic [2:0]                   face_reg;
    logic [COORD_BITS:0]          depth_reg;
    logic signed [COORD_BITS+1:0] contact_x_reg;
    logic signed [COORD_BITS+1:0] contact_y_reg;
    logic signed [COORD_BITS+1:0] contact_z_reg;

    // ---------------- datapath ----------------
    logic signed [COORD_BITS+1:0] ev_depth;
    logic                         ev_minus;
    logic signed [COORD_BITS+1:0] ev_contact;
    logic                         sel_hit;
    logic [2:0]                   sel_face;
    logic [COORD_BITS:0]          sel_depth;
    logic signed [COORD_BITS+1:0] sel_contact_x;
    logic signed [COORD_BITS+1:0] sel_contact_y;
    logic signed [COORD_BITS+1:0] sel_contact_z;

    logic in_is_z;
    logic in_is_xy;
    logic out_free;
    logic in_move;
    logic s_take;

    aop_axis_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .first_min  (first_min_reg),
        .first_max  (first_max_reg),
        .first_pos  (first_pos_reg),
        .second_min (second_min_reg),
        .second_max (second_max_reg),
        .second_pos (second_pos_reg),
        .depth      (ev_depth),
        .minus_side (ev_minus),
        .contact    (ev_contact)
    );

    aop_select #(
        .COORD_BITS (COORD_BITS)
    ) u_select (
        .depth_x      (axis_depth_reg[0]),
        .depth_y      (axis_depth_reg[1]),
        .depth_z      (ev_depth),
        .minus_x      (axis_minus_reg[0]),
        .minus_y      (axis_minus_reg[1]),
        .minus_z      (ev_minus),
        .contact_x_in (axis_contact_reg[0]),
        .contact_y_in (axis_contact_reg[1]),
        .contact_z_in (ev_contact),
        .hit          (sel_hit),
        .face         (sel_face),
        .depth        (sel_depth),
        .contact_x    (sel_contact_x),
        .contact_y    (sel_contact_y),
        .contact_z    (sel_contact_z)
    );

    // ---------------- flow control ----------------
    assign in_is_z  = (axis_reg == AXIS_Z);
    assign in_is_xy = (axis_reg == AXIS_X) || (axis_reg == AXIS_Y);
    // result register can take a new result this cycle
    assign out_free = !out_valid_reg || m_ready;
    // x, y and dropped codes always leave; a z waits for room in the result register
    assign in_move  = in_valid_reg && (!in_is_z || out_free);
    assign s_ready  = !in_valid_reg || in_move;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (in_move) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (in_move && in_is_z) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the input transaction
    always_ff @(posedge aclk) begin
        if (s_take) begin
            axis_reg       <= s_axis;
            first_min_reg  <= s_first_min;
            first_max_reg  <= s_first_max;
            first_pos_reg  <= s_first_pos;
            second_min_reg <= s_second_min;
            second_max_reg <= s_second_max;
            second_pos_reg <= s_second_pos;
        end
    end

    // hold the x and y results until overwritten; cleared only by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                axis_depth_reg[i]   <= '0;
                axis_minus_reg[i]   <= 1'b0;
                axis_contact_reg[i] <= '0;
            end
        end else if (in_move && in_is_xy) begin
            axis_depth_reg[axis_reg[0]]   <= ev_depth;
            axis_minus_reg[axis_reg[0]]   <= ev_minus;
            axis_contact_reg[axis_reg[0]] <= ev_contact;
        end
    end

    // load the result register on a z transaction
    always_ff @(posedge aclk) begin
        if (in_move && in_is_z) begin
            hit_reg       <= sel_hit;
            face_reg      <= sel_face;
            depth_reg     <= sel_depth;
            contact_x_reg <= sel_contact_x;
            contact_y_reg <= sel_contact_y;
            contact_z_reg <= sel_contact_z;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_hit       = hit_reg;
    assign m_face      = face_reg;
    assign m_depth     = depth_reg;
    assign m_contact_x = contact_x_reg;
    assign m_contact_y = contact_y_reg;
    assign m_contact_z = contact_z_reg;

endmodule

FILE: hw/rtl/aop_axis_eval.sv
// ============================================================================
// aop_axis_eval: single-axis penetration evaluation
// Forms world bounds of both boxes, both penetration depths, and keeps the
// smaller one together with its side and the contact sum.
// ============================================================================
module aop_axis_eval #(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS-1:0] first_min,
    input  logic signed [COORD_BITS-1:0] first_max,
    input  logic signed [COORD_BITS-1:0] first_pos,
    input  logic signed [COORD_BITS-1:0] second_min,
    input  logic signed [COORD_BITS-1:0] second_max,
    input  logic signed [COORD_BITS-1:0] second_pos,
    output logic signed [COORD_BITS+1:0] depth,
    output logic                         minus_side,
    output logic signed [COORD_BITS+1:0] contact
);

    logic signed [COORD_BITS:0]   f_lo;
    logic signed [COORD_BITS:0]   f_hi;
    logic signed [COORD_BITS:0]   s_lo;
    logic signed [COORD_BITS:0]   s_hi;
    logic signed [COORD_BITS+1:0] plus_d;
    logic signed [COORD_BITS+1:0] minus_d;

    // world bounds, one bit wider than the local coordinates
    assign f_lo = {first_min[COORD_BITS-1], first_min} + {first_pos[COORD_BITS-1], first_pos};
    assign f_hi = {first_max[COORD_BITS-1], first_max} + {first_pos[COORD_BITS-1], first_pos};
    assign s_lo = {second_min[COORD_BITS-1], second_min}
                + {second_pos[COORD_BITS-1], second_pos};
    assign s_hi = {second_max[COORD_BITS-1], second_max}
                + {second_pos[COORD_BITS-1], second_pos};

    assign plus_d  = {f_hi[COORD_BITS], f_hi} - {s_lo[COORD_BITS], s_lo};
    assign minus_d = {s_hi[COORD_BITS], s_hi} - {f_lo[COORD_BITS], f_lo};

    // a tie keeps the plus side
    always_comb begin
        if (plus_d > minus_d) begin
            depth      = minus_d;
            minus_side = 1'b1;
            contact    = {s_hi[COORD_BITS], s_hi} + {f_lo[COORD_BITS], f_lo};
        end else begin
            depth      = plus_d;
            minus_side = 1'b0;
            contact    = {f_hi[COORD_BITS], f_hi} + {s_lo[COORD_BITS], s_lo};
        end
    end

endmodule

FILE: hw/rtl/aop_select.sv
// ============================================================================
// aop_select: least-penetration axis selection
// Picks the axis with the least kept depth (ties to the lower axis) and
// forms the hit flag, face index, depth and contact point.
// ============================================================================
module aop_select
    import aop_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS+1:0] depth_x,
    input  logic signed [COORD_BITS+1:0] depth_y,
    input  logic signed [COORD_BITS+1:0] depth_z,
    input  logic                         minus_x,
    input  logic                         minus_y,
    input  logic                         minus_z,
    input  logic signed [COORD_BITS+1:0] contact_x_in,
    input  logic signed [COORD_BITS+1:0] contact_y_in,
    input  logic signed [COORD_BITS+1:0] contact_z_in,
    output logic                         hit,
    output logic [2:0]                   face,
    output logic [COORD_BITS:0]          depth,
    output logic signed [COORD_BITS+1:0] contact_x,
    output logic signed [COORD_BITS+1:0] contact_y,
    output logic signed [COORD_BITS+1:0] contact_z
);

    logic signed [COORD_BITS+1:0] d_xy;
    logic                         m_xy;
    logic [1:0]                   a_xy;
    logic signed [COORD_BITS+1:0] d_best;
    logic                         m_best;
    logic [1:0]                   a_best;

    always_comb begin
        if (depth_x > depth_y) begin
            d_xy = depth_y;
            m_xy = minus_y;
            a_xy = AXIS_Y;
        end else begin
            d_xy = depth_x;
            m_xy = minus_x;
            a_xy = AXIS_X;
        end

        if (d_xy > depth_z) begin
            d_best = depth_z;
            m_best = minus_z;
            a_best = AXIS_Z;
        end else begin
            d_best = d_xy;
            m_best = m_xy;
            a_best = a_xy;
        end

        hit = (d_best > 0);
        if (hit) begin
            face      = {1'b0, a_best} + (m_best ? FACE_MINUS_OFS : 3'd0);
            depth     = d_best[COORD_BITS:0];
            contact_x = contact_x_in;
            contact_y = contact_y_in;
            contact_z = contact_z_in;
        end else begin
            face      = 3'd0;
            depth     = '0;
            contact_x = '0;
            contact_y = '0;
            contact_z = '0;
        end
    end

endmodule
